FILE: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation and status codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int NumW  = 64;
    localparam int DenW  = 63;
    localparam int WideW = 128;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CMP  = 3'd4,
        OP_NEG  = 3'd5,
        OP_NORM = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ZERO_DEN = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [NumW-1:0]   a_num;
        logic [NumW-1:0]   a_den;
        logic [NumW-1:0]   b_num;
        logic [DenW-1:0]   b_den;
    } req_t;

    typedef struct packed {
        logic [NumW-1:0] res_num;
        logic [DenW-1:0] res_den;
        logic [1:0]      cmp_result;
        logic [1:0]      status;
    } rsp_t;

    // command to the shared datapath
    typedef struct packed {
        logic start;
        logic [1:0] func;
    } dp_cmd_t;

    localparam logic [1:0] FN_MUL = 2'd0;
    localparam logic [1:0] FN_DIV = 2'd1;
    localparam logic [1:0] FN_GCD = 2'd2;

endpackage

FILE: rtl/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface rau_req_if;
    logic          valid;
    logic          ready;
    rau_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
    logic          valid;
    logic          ready;
    rau_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu
// Shared multi-cycle unit: shift-add multiply, restoring divide, binary gcd
// ----------------------------------------------------------------------------
module rau_alu
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rau_pkg::dp_cmd_t              cmd,
    input  logic [rau_pkg::WideW-1:0]     op_a,
    input  logic [rau_pkg::WideW-1:0]     op_b,
    output logic                          done,
    output logic [rau_pkg::WideW-1:0]     result
);

    localparam int W = rau_pkg::WideW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_GCD_TWO,
        S_GCD_A,
        S_GCD_B,
        S_GCD_SUB,
        S_GCD_SHL
    } state_t;

    state_t         state_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   rem_reg;
    logic [7:0]     cnt_reg;
    logic           done_reg;

    logic [W:0]     rem_sh;
    logic [W:0]     rem_diff;

    assign rem_sh   = {rem_reg, a_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, b_reg};
    assign done     = done_reg;
    assign result   = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        a_reg   <= op_a;
                        b_reg   <= op_b;
                        acc_reg <= '0;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        unique case (cmd.func)
                            rau_pkg::FN_MUL: state_reg <= S_MUL;
                            rau_pkg::FN_DIV: state_reg <= S_DIV;
                            default:         state_reg <= S_GCD_TWO;
                        endcase
                    end
                end
                S_MUL:
                begin
                    // 64-bit operands, one bit a cycle
                    if (b_reg[0])
                        acc_reg <= acc_reg + a_reg;
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd63)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (!rem_diff[W])
                    begin
                        rem_reg <= rem_diff[W-1:0];
                        acc_reg <= {acc_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[W-1:0];
                        acc_reg <= {acc_reg[W-2:0], 1'b0};
                    end
                    a_reg   <= a_reg << 1;
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd127)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_GCD_TWO:
                begin
                    if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg   <= a_reg >> 1;
                        b_reg   <= b_reg >> 1;
                        cnt_reg <= cnt_reg + 8'd1;
                    end
                    else
                        state_reg <= S_GCD_A;
                end
                S_GCD_A:
                begin
                    if (!a_reg[0])
                        a_reg <= a_reg >> 1;
                    else
                        state_reg <= S_GCD_B;
                end
                S_GCD_B:
                begin
                    if (b_reg == '0)
                    begin
                        acc_reg   <= a_reg;
                        state_reg <= S_GCD_SHL;
                    end
                    else if (!b_reg[0])
                        b_reg <= b_reg >> 1;
                    else
                        state_reg <= S_GCD_SUB;
                end
                S_GCD_SUB:
                begin
                    if (a_reg > b_reg)
                    begin
                        a_reg <= b_reg;
                        b_reg <= a_reg - b_reg;
                    end
                    else
                        b_reg <= b_reg - a_reg;
                    state_reg <= S_GCD_B;
                end
                S_GCD_SHL:
                begin
                    if (cnt_reg != 8'd0)
                    begin
                        acc_reg <= acc_reg << 1;
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/rau_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_seq
// Sequencer: decodes the request and steps the shared unit to a result
// ----------------------------------------------------------------------------
module rau_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    rau_req_if.sink                       req,
    rau_rsp_if.source                     rsp,
    output rau_pkg::dp_cmd_t              cmd,
    output logic [rau_pkg::WideW-1:0]     op_a,
    output logic [rau_pkg::WideW-1:0]     op_b,
    input  logic                          alu_done,
    input  logic [rau_pkg::WideW-1:0]     alu_res
);

    localparam int W  = rau_pkg::WideW;
    localparam int NW = rau_pkg::NumW;
    localparam int DW = rau_pkg::DenW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_M1,
        S_M2,
        S_M3,
        S_SUM,
        S_CMP,
        S_GCD,
        S_QN,
        S_QD,
        S_FIN,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic [2:0]            op_reg;
    logic [NW-1:0]         anm_reg, adm_reg, bnm_reg;
    logic [DW-1:0]         bd_reg;
    logic                  aneg_reg, bneg_reg;
    logic [W-1:0]          x_reg, y_reg, d_reg, g_reg;
    logic                  xneg_reg, yneg_reg;
    logic                  busy_reg;
    logic                  rv_reg;
    rau_pkg::rsp_t         out_reg;
    rau_pkg::dp_cmd_t      cmd_reg;
    logic [W-1:0]          opa_reg, opb_reg;

    logic [NW-1:0]         in_anm, in_adm, in_bnm;

    assign in_anm = req.data.a_num[NW-1] ? (NW)'(-req.data.a_num) : req.data.a_num;
    assign in_adm = req.data.a_den[NW-1] ? (NW)'(-req.data.a_den) : req.data.a_den;
    assign in_bnm = req.data.b_num[NW-1] ? (NW)'(-req.data.b_num) : req.data.b_num;

    assign req.ready = !busy_reg && !rv_reg;
    assign rsp.valid = rv_reg;
    assign rsp.data  = out_reg;
    assign cmd       = cmd_reg;
    assign op_a      = opa_reg;
    assign op_b      = opb_reg;

    function automatic rau_pkg::rsp_t mk_rsp(logic [NW-1:0] n, logic [DW-1:0] d,
                                             logic [1:0] c, rau_pkg::status_t s);
        rau_pkg::rsp_t r;
        r.res_num    = n;
        r.res_den    = d;
        r.cmp_result = c;
        r.status     = s;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            cmd_reg.start <= 1'b0;
            if (rsp.valid && rsp.ready)
                rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        op_reg    <= req.data.req_type;
                        anm_reg   <= in_anm;
                        adm_reg   <= in_adm;
                        bnm_reg   <= in_bnm;
                        bd_reg    <= req.data.b_den;
                        aneg_reg  <= req.data.a_num[NW-1] ^ req.data.a_den[NW-1];
                        bneg_reg  <= req.data.b_num[NW-1];
                        busy_reg  <= 1'b1;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    if (op_reg == rau_pkg::OP_NONE)
                    begin
                        out_reg   <= mk_rsp('0, '0, 2'b00, rau_pkg::ST_OK);
                        state_reg <= S_OUT;
                    end
                    else if (adm_reg == '0 || (op_reg <= rau_pkg::OP_CMP && bd_reg == '0)
                             || (op_reg == rau_pkg::OP_DIV && bnm_reg == '0))
                    begin
                        out_reg   <= mk_rsp('0, '0, 2'b00, rau_pkg::ST_ZERO_DEN);
                        state_reg <= S_OUT;
                    end
                    else if (op_reg == rau_pkg::OP_NEG || op_reg == rau_pkg::OP_NORM)
                    begin
                        x_reg     <= {{(W-NW){1'b0}}, anm_reg};
                        xneg_reg  <= (op_reg == rau_pkg::OP_NEG) ? !aneg_reg : aneg_reg;
                        d_reg     <= {{(W-NW){1'b0}}, adm_reg};
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        // first product: numerator of a side
                        cmd_reg.start <= 1'b1;
                        cmd_reg.func  <= rau_pkg::FN_MUL;
                        opa_reg <= {{(W-NW){1'b0}}, anm_reg};
                        opb_reg <= (op_reg == rau_pkg::OP_MUL)
                                   ? {{(W-NW){1'b0}}, bnm_reg}
                                   : {{(W-DW){1'b0}}, bd_reg};
                        xneg_reg  <= (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV)
                                     ? (aneg_reg ^ bneg_reg) : aneg_reg;
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    if (alu_done)
                    begin
                        x_reg <= alu_res;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.func  <= rau_pkg::FN_MUL;
                        opa_reg <= {{(W-NW){1'b0}}, adm_reg};
                        opb_reg <= (op_reg == rau_pkg::OP_DIV)
                                   ? {{(W-NW){1'b0}}, bnm_reg}
                                   : {{(W-DW){1'b0}}, bd_reg};
                        state_reg <= S_M2;
                    end
                end
                S_M2:
                begin
                    if (alu_done)
                    begin
                        if (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV)
                        begin
                            d_reg     <= alu_res;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            d_reg <= alu_res;
                            cmd_reg.start <= 1'b1;
                            cmd_reg.func  <= rau_pkg::FN_MUL;
                            opa_reg <= {{(W-NW){1'b0}}, bnm_reg};
                            opb_reg <= {{(W-NW){1'b0}}, adm_reg};
                            yneg_reg <= (op_reg == rau_pkg::OP_SUB) ? !bneg_reg : bneg_reg;
                            state_reg <= S_M3;
                        end
                    end
                end
                S_M3:
                begin
                    if (alu_done)
                    begin
                        y_reg     <= alu_res;
                        state_reg <= (op_reg == rau_pkg::OP_CMP) ? S_CMP : S_SUM;
                    end
                end
                S_CMP:
                begin
                    logic xn, yn;
                    xn = xneg_reg && (x_reg != '0);
                    yn = yneg_reg && (y_reg != '0);
                    if (xn != yn)
                        out_reg <= mk_rsp('0, '0, xn ? 2'b11 : 2'b01, rau_pkg::ST_OK);
                    else if (x_reg == y_reg)
                        out_reg <= mk_rsp('0, '0, 2'b00, rau_pkg::ST_OK);
                    else if ((x_reg > y_reg) ^ xn)
                        out_reg <= mk_rsp('0, '0, 2'b01, rau_pkg::ST_OK);
                    else
                        out_reg <= mk_rsp('0, '0, 2'b11, rau_pkg::ST_OK);
                    state_reg <= S_OUT;
                end
                S_SUM:
                begin
                    if (xneg_reg == yneg_reg)
                        x_reg <= x_reg + y_reg;
                    else if (x_reg >= y_reg)
                        x_reg <= x_reg - y_reg;
                    else
                    begin
                        x_reg    <= y_reg - x_reg;
                        xneg_reg <= yneg_reg;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (x_reg == '0)
                    begin
                        out_reg   <= mk_rsp('0, DW'(1), 2'b00, rau_pkg::ST_OK);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cmd_reg.start <= 1'b1;
                        cmd_reg.func  <= rau_pkg::FN_GCD;
                        opa_reg   <= x_reg;
                        opb_reg   <= d_reg;
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (alu_done)
                    begin
                        g_reg <= alu_res;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.func  <= rau_pkg::FN_DIV;
                        opa_reg   <= x_reg;
                        opb_reg   <= alu_res;
                        state_reg <= S_QN;
                    end
                end
                S_QN:
                begin
                    if (alu_done)
                    begin
                        x_reg <= alu_res;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.func  <= rau_pkg::FN_DIV;
                        opa_reg   <= d_reg;
                        opb_reg   <= g_reg;
                        state_reg <= S_QD;
                    end
                end
                S_QD:
                begin
                    if (alu_done)
                    begin
                        if (alu_res[W-1:DW] == '0 && x_reg[W-1:NW] == '0
                            && (x_reg[NW-1] == 1'b0
                                || (xneg_reg && x_reg[NW-2:0] == '0)))
                            out_reg <= mk_rsp(xneg_reg ? (NW)'(-x_reg[NW-1:0])
                                                       : x_reg[NW-1:0],
                                              alu_res[DW-1:0], 2'b00, rau_pkg::ST_OK);
                        else
                            out_reg <= mk_rsp('0, '0, 2'b00, rau_pkg::ST_OVERFLOW);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    rv_reg    <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact 64-bit rational add, subtract, multiply, divide, compare, negate and
// normalise on one shared multiply/divide/gcd unit
// ----------------------------------------------------------------------------
//  port   dir  fields
//  req    in   req_type a_num a_den b_num b_den
//  rsp    out  res_num res_den cmp_result status
//
//  one transaction at a time; an unused code, a zero denominator, or a
//  negate or normalise of a zero numerator does not use the shared unit;
//  otherwise the run time is set by the shared unit: its shift-add
//  products, restoring quotients and the binary gcd loop on 128-bit operands.
//  ready is low from acceptance until the result is taken.
//  no clearing pass after reset; rsp may stall indefinitely.
// ----------------------------------------------------------------------------
module rational_arith_unit
(
    input  logic      clk,
    input  logic      rst_n,
    rau_req_if.sink   req,
    rau_rsp_if.source rsp
);

    rau_pkg::dp_cmd_t              cmd;
    logic [rau_pkg::WideW-1:0]     op_a;
    logic [rau_pkg::WideW-1:0]     op_b;
    logic                          alu_done;
    logic [rau_pkg::WideW-1:0]     alu_res;

    rau_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .done   (alu_done),
        .result (alu_res)
    );

    rau_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cmd      (cmd),
        .op_a     (op_a),
        .op_b     (op_b),
        .alu_done (alu_done),
        .alu_res  (alu_res)
    );

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted with a result pending");

    a_cmp_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.cmp_result != 2'b00) |-> rsp.data.status == rau_pkg::ST_OK)
        else $error("compare answer with error status");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status != rau_pkg::ST_OK) |-> rsp.data.res_den == '0)
        else $error("error result carries a denominator");

endmodule

FILE: bench/tb_rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit
// Drives directed and random rational operations through the request channel
// and checks every result against an in-bench 128-bit predictor or, for typed directed rows, a tabled answer
// ----------------------------------------------------------------------------
module tb_rational_arith_unit;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        rau_pkg::op_t  op;
        logic [63:0]   an;
        logic [63:0]   ad;
        logic [63:0]   bn;
        logic [62:0]   bd;
        bit            typed;
        rau_pkg::rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;
    rau_req_if req ();
    rau_rsp_if rsp ();

    rational_arith_unit dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    rau_pkg::rsp_t expected_q[$];
    int            errors;
    int            send_idle;
    int            recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb_rational_arith_unit: FAIL");
        $finish;
    end

    function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
        logic [127:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic rau_pkg::rsp_t reduce_emit(bit neg, logic [127:0] n,
                                                  logic [127:0] d);
        rau_pkg::rsp_t r;
        logic [127:0]  g;
        r = '0;
        if (n == 0)
        begin
            r.res_den = 63'd1;
            return r;
        end
        g = gcd128(n, d);
        n = n / g;
        d = d / g;
        if (d > {65'd0, MAX63} || n > (neg ? {64'd0, MIN64} : {64'd0, MAX64}))
        begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.res_num = neg ? -n[63:0] : n[63:0];
        r.res_den = d[62:0];
        return r;
    endfunction

    function automatic rau_pkg::rsp_t rational_result(rau_pkg::req_t q);
        rau_pkg::rsp_t r;
        bit            an_s, bn_s, x_s, y_s, s;
        logic [63:0]   anm, adm, bnm;
        logic [127:0]  bd, x, y, m;
        r = '0;
        an_s = q.a_num[63] ^ q.a_den[63];
        bn_s = q.b_num[63];
        anm = q.a_num[63] ? -q.a_num : q.a_num;
        adm = q.a_den[63] ? -q.a_den : q.a_den;
        bnm = q.b_num[63] ? -q.b_num : q.b_num;
        bd = {65'd0, q.b_den};
        if (q.req_type == rau_pkg::OP_NONE)
            return r;
        if (adm == 0 || (q.req_type <= rau_pkg::OP_CMP && q.b_den == 0))
        begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        x = {64'd0, anm} * bd;
        y = {64'd0, bnm} * {64'd0, adm};
        case (rau_pkg::op_t'(q.req_type))
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                x_s = an_s;
                y_s = (q.req_type == rau_pkg::OP_SUB) ? !bn_s : bn_s;
                if (x_s == y_s)
                begin
                    m = x + y;
                    s = x_s;
                end
                else if (x >= y)
                begin
                    m = x - y;
                    s = x_s;
                end
                else
                begin
                    m = y - x;
                    s = y_s;
                end
                r = reduce_emit(s, m, {64'd0, adm} * bd);
            end
            rau_pkg::OP_MUL: r = reduce_emit(an_s ^ bn_s, {64'd0, anm} * {64'd0, bnm},
                                             {64'd0, adm} * bd);
            rau_pkg::OP_DIV:
            begin
                if (bnm == 0)
                    r.status = rau_pkg::ST_ZERO_DEN;
                else
                    r = reduce_emit(an_s ^ bn_s, x, {64'd0, adm} * {64'd0, bnm});
            end
            rau_pkg::OP_CMP:
            begin
                x_s = (x != 0) && an_s;
                y_s = (y != 0) && bn_s;
                if (x_s != y_s)
                    r.cmp_result = x_s ? 2'b11 : 2'b01;
                else if (x == y)
                    r.cmp_result = 2'b00;
                else
                    r.cmp_result = ((x > y) ^ x_s) ? 2'b01 : 2'b11;
            end
            rau_pkg::OP_NEG: r = reduce_emit(!an_s, {64'd0, anm}, {64'd0, adm});
            default:         r = reduce_emit(an_s, {64'd0, anm}, {64'd0, adm});
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(0, 40)) - 20);
            2: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
            3: return ($urandom_range(0, 1) != 0) ? MIN64 + $urandom_range(0, 3)
                                                  : MAX64 - $urandom_range(0, 3);
            4: return 64'($signed($urandom_range(0, 2000)) - 1000) * 64'd720;
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic send(rau_pkg::req_t q);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.data  <= q;
        req.valid <= 1'b1;
        expected_q.push_back(rational_result(q));
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        rau_pkg::req_t q;
        q.req_type = ($urandom_range(0, 40) == 0) ? rau_pkg::OP_NONE
                                                  : 3'($urandom_range(0, 6));
        q.a_num = rand64();
        q.b_num = rand64();
        q.a_den = rand64();
        if (q.req_type != rau_pkg::OP_NORM && q.a_den[63] && $urandom_range(0, 3) != 0)
            q.a_den = -q.a_den;
        if (q.a_den == 0 && $urandom_range(0, 3) != 0)
            q.a_den = 64'd1;
        q.b_den = 63'(rand64());
        if (q.b_den == 0 && $urandom_range(0, 3) != 0)
            q.b_den = 63'd1;
        send(q);
    endtask

    always @(negedge clk)
        rsp.ready <= rst_n ? ($urandom_range(0, 99) >= recv_idle) : 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%t unexpected transaction %h", $time, rsp.data);
                errors++;
            end
            else if (rsp.data !== expected_q[0])
            begin
                $display("%t mismatch expected %h actual %h", $time,
                         expected_q[0], rsp.data);
                errors++;
                void'(expected_q.pop_front());
            end
            else
                void'(expected_q.pop_front());
        end
    end

    row_t dir[$];

    function automatic row_t mk(rau_pkg::op_t op, logic [63:0] an, logic [63:0] ad,
                                logic [63:0] bn, logic [62:0] bd, bit typed,
                                logic [63:0] rn, logic [62:0] rd, logic [1:0] c,
                                rau_pkg::status_t st);
        row_t r;
        r.op = op; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd; r.typed = typed;
        r.want = '{res_num: rn, res_den: rd, cmp_result: c, status: st};
        return r;
    endfunction

    initial
    begin
        rau_pkg::req_t q;
        int            wait_cnt;
        errors = 0;
        send_idle = 10;
        recv_idle = 56;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        dir.push_back(mk(rau_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 1, 0, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_MUL, 2, 3, 3, 4, 1, 1, 2, 0, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_DIV, 1, 2, 0, 1, 1, 0, 0, 0, rau_pkg::ST_ZERO_DEN));
        dir.push_back(mk(rau_pkg::OP_CMP, 1, 2, 1, 3, 1, 0, 0, 2'b01, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_CMP, -1, 2, 1, 3, 1, 0, 0, 2'b11, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_CMP, 2, 4, 1, 2, 1, 0, 0, 2'b00, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_NEG, MIN64, 1, 0, 1, 1, 0, 0, 0,
                         rau_pkg::ST_OVERFLOW));
        dir.push_back(mk(rau_pkg::OP_NORM, 6, -4, 0, 1, 1, -3, 2, 0, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_NORM, MIN64, MIN64, 0, 1, 1, 1, 1, 0,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_NORM, 0, -7, 0, 1, 1, 0, 1, 0, rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_ADD, 1, 0, 1, 1, 1, 0, 0, 0, rau_pkg::ST_ZERO_DEN));
        dir.push_back(mk(rau_pkg::OP_ADD, 1, 1, 1, 0, 1, 0, 0, 0, rau_pkg::ST_ZERO_DEN));
        dir.push_back(mk(rau_pkg::OP_NEG, 5, 0, 0, 0, 1, 0, 0, 0, rau_pkg::ST_ZERO_DEN));
        dir.push_back(mk(rau_pkg::OP_NONE, -1, -1, -1, MAX63, 1, 0, 0, 0,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_ADD, MAX64, 1, MAX64, 1, 1, 0, 0, 0,
                         rau_pkg::ST_OVERFLOW));
        dir.push_back(mk(rau_pkg::OP_MUL, MIN64, 1, MIN64, 1, 1, 0, 0, 0,
                         rau_pkg::ST_OVERFLOW));
        dir.push_back(mk(rau_pkg::OP_MUL, MIN64, 1, -1, 1, 1, 0, 0, 0,
                         rau_pkg::ST_OVERFLOW));
        dir.push_back(mk(rau_pkg::OP_DIV, 1, MAX64, MIN64, 1, 0, 0, 0, 0,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_SUB, MIN64, 1, MAX64, MAX63, 0, 0, 0, 0,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_CMP, MAX64, 1, MIN64, 1, 1, 0, 0, 2'b01,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_DIV, MAX64, MAX64, 1, MAX63, 0, 0, 0, 0,
                         rau_pkg::ST_OK));
        dir.push_back(mk(rau_pkg::OP_CMP, 0, -3, 0, MAX63, 1, 0, 0, 2'b00,
                         rau_pkg::ST_OK));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (dir[i])
        begin
            q = '{req_type: dir[i].op, a_num: dir[i].an, a_den: dir[i].ad,
                  b_num: dir[i].bn, b_den: dir[i].bd};
            send(q);
            if (dir[i].typed)
                expected_q[$] = dir[i].want;
        end
        for (int i = 0; i < 1500; i++)
        begin
            if (i == 500)
            begin
                send_idle = 56;
                recv_idle = 10;
            end
            if (i == 1000)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_random();
        end
        req.valid <= 1'b0;
        wait_cnt = 0;
        while (expected_q.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (1000) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_rational_arith_unit: PASS");
        else
            $display("tb_rational_arith_unit: FAIL");
        $finish;
    end

endmodule
